// ===== sv/bst_pkg.sv =====
// bst_pkg: shared types and constants of the background SAD threshold block
// no dependencies; used by bst_cfg_regs, bst_datapath and background_sad_threshold

package bst_pkg;

	// register widths and fixed-point formats
	localparam int ALPHA_W    = 16;
	localparam int COEFF_W    = 16;
	localparam int BG_FRAC    = 16;
	localparam int COEFF_FRAC = 8;

	// configuration register map
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_FILTER_ALPHA    = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_COEFF = 1'd1;

	// register reset values
	localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd64880;
	localparam logic [COEFF_W-1:0] COEFF_RESET = 16'd256;

	// current configuration as seen by the datapath
	typedef struct packed {
		logic [ALPHA_W-1:0] alpha;
		logic [COEFF_W-1:0] coeff;
	} bst_cfg_t;

endpackage

// ===== sv/bst_cfg_regs.sv =====
// bst_cfg_regs: filter_alpha and threshold_coeff registers behind the write port
// depends on bst_pkg

module bst_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [bst_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bst_pkg::ALPHA_W-1:0]     cfg_wdata,
	output bst_pkg::bst_cfg_t               cfg
);
	import bst_pkg::*;

	logic [ALPHA_W-1:0] alpha_q;
	logic [COEFF_W-1:0] coeff_q;

	// register writes, decoded by index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= ALPHA_RESET;
			coeff_q <= COEFF_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_FILTER_ALPHA:    alpha_q <= cfg_wdata;
				REG_THRESHOLD_COEFF: coeff_q <= COEFF_W'(cfg_wdata);
				default: ;
			endcase
		end
	end

	assign cfg.alpha = alpha_q;
	assign cfg.coeff = coeff_q;

endmodule

// ===== sv/bst_datapath.sv =====
// bst_datapath: single-pass logic for one SAD request: threshold, adjusted value,
// history test and exponential background update; depends on bst_pkg

module bst_datapath #(
	parameter int SAD_WIDTH       = 31,
	parameter int ALPHA_FRAC_BITS = 16
) (
	input  logic [SAD_WIDTH-1:0]             sad,
	input  logic [SAD_WIDTH+bst_pkg::BG_FRAC-1:0] bg,
	input  logic [SAD_WIDTH-1:0]             hist_one,
	input  logic [SAD_WIDTH-1:0]             hist_two,
	input  logic [SAD_WIDTH-1:0]             hist_three,
	input  bst_pkg::bst_cfg_t                cfg,
	output logic [SAD_WIDTH-1:0]             result,
	output logic [SAD_WIDTH-1:0]             adj,
	output logic                             upd,
	output logic [SAD_WIDTH+bst_pkg::BG_FRAC-1:0] bg_next
);
	import bst_pkg::*;

	localparam int W  = SAD_WIDTH;
	localparam int BW = W + BG_FRAC;
	localparam int PW = BW + COEFF_W;
	localparam int TW = PW - BG_FRAC - COEFF_FRAC;
	localparam int HW = W + COEFF_W;
	localparam int AW = (ALPHA_FRAC_BITS + 1 > ALPHA_W) ? ALPHA_FRAC_BITS + 1 : ALPHA_W + 1;
	localparam int SW = BW + AW + 1;

	logic [PW-1:0] thr_prod;
	logic [TW-1:0] thr;
	logic [W:0]    adj_sum;
	logic [W-1:0]  adj_sat;
	logic [HW-1:0] adj_scaled;
	logic [HW-1:0] lim_one, lim_two, lim_three;
	logic [AW-1:0] alpha_one, alpha_in, alpha_sat, beta;
	logic [SW-1:0] prod_old, prod_new, blend, blend_shr, bg_max;

	// threshold = background * coeff, integer part
	assign thr_prod = PW'(bg) * PW'(cfg.coeff);
	assign thr      = thr_prod[PW-1 -: TW];
	assign result   = (TW'(sad) > thr) ? (sad - thr[W-1:0]) : '0;

	// adjusted value: sad plus a quarter of the last one, clamped to [1, max]
	assign adj_sum = {1'b0, sad} + (W+1)'(hist_one >> 2);
	assign adj_sat = adj_sum[W] ? '1 : adj_sum[W-1:0];
	assign adj     = (adj_sat == '0) ? W'(1) : adj_sat;

	// history test: adj * 256 <= hist * coeff for all three entries
	assign adj_scaled = HW'(adj) << COEFF_FRAC;
	assign lim_one    = HW'(hist_one) * HW'(cfg.coeff);
	assign lim_two    = HW'(hist_two) * HW'(cfg.coeff);
	assign lim_three  = HW'(hist_three) * HW'(cfg.coeff);
	assign upd = (adj_scaled <= lim_one) && (adj_scaled <= lim_two) &&
	             (adj_scaled <= lim_three);

	// alpha clamped to one, weight of the new value is one minus alpha
	assign alpha_one = AW'(1) << ALPHA_FRAC_BITS;
	assign alpha_in  = AW'(cfg.alpha);
	assign alpha_sat = (alpha_in > alpha_one) ? alpha_one : alpha_in;
	assign beta      = alpha_one - alpha_sat;

	// exponential average, truncated and saturated to the background range
	assign prod_old  = SW'(bg) * SW'(alpha_sat);
	assign prod_new  = SW'({adj, {BG_FRAC{1'b0}}}) * SW'(beta);
	assign blend     = prod_old + prod_new;
	assign blend_shr = blend >> ALPHA_FRAC_BITS;
	assign bg_max    = SW'({{W{1'b1}}, {BG_FRAC{1'b0}}});
	assign bg_next   = (blend_shr > bg_max) ? bg_max[BW-1:0] : blend_shr[BW-1:0];

endmodule

// ===== sv/background_sad_threshold.sv =====
// background_sad_threshold: one request enters per cycle unless the output stalls;
// it passes the input register, then the result register. The combinational
// datapath updates background and history in place. Output register parts the
// sides: a new request enters an empty input register while a result waits.
// arst_n clears background, history, valids and loads config reset values.
// Depends on bst_pkg, bst_cfg_regs and bst_datapath.

module background_sad_threshold #(
	parameter int SAD_WIDTH       = 31,
	parameter int ALPHA_FRAC_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [((SAD_WIDTH+7)/8)*8-1:0]        s_tdata,  // sad_value
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [((SAD_WIDTH+7)/8)*8-1:0]        m_tdata,  // thresholded_sad
	output logic                                 m_tuser,  // background_updated
	input  logic                                 cfg_wr_en,
	input  logic [bst_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [bst_pkg::ALPHA_W-1:0]          cfg_wdata
);
	import bst_pkg::*;

	localparam int W  = SAD_WIDTH;
	localparam int BW = W + BG_FRAC;
	localparam int DW = ((W + 7) / 8) * 8;

	bst_cfg_t cfg;

	logic          valid_s1;
	logic [W-1:0]  sad_s1;
	logic          fire;
	logic [BW-1:0] bg_q;
	logic [W-1:0]  hist_one_q, hist_two_q, hist_three_q;
	logic          m_valid_q;
	logic [W-1:0]  result_q;
	logic          upd_q;
	logic [W-1:0]  result, adj;
	logic          upd;
	logic [BW-1:0] bg_next;

	bst_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	bst_datapath #(
		.SAD_WIDTH       (SAD_WIDTH),
		.ALPHA_FRAC_BITS (ALPHA_FRAC_BITS)
	) u_dp (
		.sad        (sad_s1),
		.bg         (bg_q),
		.hist_one   (hist_one_q),
		.hist_two   (hist_two_q),
		.hist_three (hist_three_q),
		.cfg        (cfg),
		.result     (result),
		.adj        (adj),
		.upd        (upd),
		.bg_next    (bg_next)
	);

	// handshake: stage 1 moves on when the result register is free or drains
	assign fire     = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !valid_s1 || fire;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			sad_s1 <= s_tdata[W-1:0];
		end
	end

	// background and history state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bg_q         <= '0;
			hist_one_q   <= '0;
			hist_two_q   <= '0;
			hist_three_q <= '0;
		end else if (fire) begin
			if (upd) begin
				bg_q <= bg_next;
			end
			hist_three_q <= hist_two_q;
			hist_two_q   <= hist_one_q;
			hist_one_q   <= adj;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (fire) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result_q <= result;
			upd_q    <= upd;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = DW'(result_q);
	assign m_tuser  = upd_q;

endmodule
